### hw/rtl/lzwd_pkg.sv
// Shared types and constants for the LZW variable-width decoder.
package lzwd_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int DICT_SIZE     = 1 << MAX_CODE_BITS;
    localparam int STACK_SIZE    = DICT_SIZE + 1;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int IDX_W         = MAX_CODE_BITS + 1;
    localparam int WIDTH_W       = 4;
    localparam int ACC_W         = 20;
    localparam int HELD_W        = 5;
    localparam int LIMIT_W       = 25;

    localparam logic [CODE_W-1:0]  CLEAR_CODE  = CODE_W'(256);
    localparam logic [CODE_W-1:0]  END_CODE    = CODE_W'(257);
    localparam logic [CODE_W-1:0]  FIRST_FREE  = CODE_W'(258);
    localparam logic [WIDTH_W-1:0] START_WIDTH = WIDTH_W'(9);
    localparam logic [WIDTH_W-1:0] TOP_WIDTH   = WIDTH_W'(MAX_CODE_BITS);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16777216);

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_PULL  = 2'd1;
    localparam logic [1:0] KIND_BEGIN = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PUSH,
        ST_CLASS,
        ST_WALK_CHK,
        ST_WALK_RD,
        ST_WALK_DAT,
        ST_WALK_END,
        ST_EMIT,
        ST_LAST,
        ST_FIN,
        ST_SETDONE,
        ST_POP_RD,
        ST_POP_DAT,
        ST_BEGIN,
        ST_RESP
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_PUSH,
        OP_CLASS,
        OP_WALK_RD,
        OP_WALK_DAT,
        OP_WALK_END,
        OP_EMIT,
        OP_LAST,
        OP_FIN,
        OP_SETDONE,
        OP_POP_RD,
        OP_POP_DAT,
        OP_BEGIN,
        OP_RESP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       push_rej;
        logic       code_ready;
        logic       is_end;
        logic       is_clear;
        logic       is_first;
        logic       walk_go;
        logic       last;
        logic       depth_zero;
        logic       in_ended;
        logic       fin_go;
        logic       out_free;
    } status_t;

endpackage

### hw/rtl/lzwd_ctrl.sv
// Sequencing state machine for the LZW decoder.
module lzwd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lzwd_pkg::status_t sts,
    output lzwd_pkg::cmd_t    cmd
);
    import lzwd_pkg::*;

    state_t state_reg, state_next;
    logic   fin_mode_reg, fin_mode_next;
    state_t after_code;

    // where a finished code returns to
    assign after_code = fin_mode_reg ? ST_SETDONE : ST_LAST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fin_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fin_mode_reg <= fin_mode_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fin_mode_next = fin_mode_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                priority if (sts.kind == KIND_PUSH) state_next = ST_PUSH;
                else if (sts.kind == KIND_PULL)
                    state_next = sts.depth_zero ? ST_RESP : ST_POP_RD;
                else if (sts.kind == KIND_BEGIN) state_next = ST_BEGIN;
                else state_next = ST_RESP;
            end
            ST_PUSH:
            begin
                priority if (sts.push_rej) state_next = ST_RESP;
                else if (sts.code_ready) state_next = ST_CLASS;
                else state_next = ST_LAST;
            end
            ST_CLASS:
            begin
                priority if (sts.is_end || sts.is_clear) state_next = after_code;
                else if (sts.is_first) state_next = ST_EMIT;
                else state_next = ST_WALK_CHK;
            end
            ST_WALK_CHK: state_next = sts.walk_go ? ST_WALK_RD : ST_WALK_END;
            ST_WALK_RD:  state_next = ST_WALK_DAT;
            ST_WALK_DAT: state_next = ST_WALK_CHK;
            ST_WALK_END: state_next = ST_EMIT;
            ST_EMIT:     state_next = after_code;
            ST_LAST:
                state_next = (sts.last && sts.depth_zero) ? ST_FIN : ST_RESP;
            ST_FIN:
            begin
                if (sts.fin_go)
                begin
                    state_next    = ST_CLASS;
                    fin_mode_next = 1'b1;
                end
                else
                    state_next = ST_SETDONE;
            end
            ST_SETDONE:
            begin
                state_next    = ST_RESP;
                fin_mode_next = 1'b0;
            end
            ST_POP_RD:   state_next = ST_POP_DAT;
            ST_POP_DAT:
                state_next = (sts.depth_zero && sts.in_ended) ? ST_FIN : ST_RESP;
            ST_BEGIN:    state_next = ST_RESP;
            ST_RESP:     if (sts.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_ACCEPT;
            end
            ST_PUSH:     cmd.op = OP_PUSH;
            ST_CLASS:    cmd.op = OP_CLASS;
            ST_WALK_RD:  cmd.op = OP_WALK_RD;
            ST_WALK_DAT: cmd.op = OP_WALK_DAT;
            ST_WALK_END: cmd.op = OP_WALK_END;
            ST_EMIT:     cmd.op = OP_EMIT;
            ST_LAST:     cmd.op = OP_LAST;
            ST_FIN:      cmd.op = OP_FIN;
            ST_SETDONE:  cmd.op = OP_SETDONE;
            ST_POP_RD:   cmd.op = OP_POP_RD;
            ST_POP_DAT:  cmd.op = OP_POP_DAT;
            ST_BEGIN:    cmd.op = OP_BEGIN;
            ST_RESP:     if (sts.out_free) cmd.op = OP_RESP;
            default:     cmd.op = OP_NONE;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held after accepted transaction");
    a_fin_mode_scope: assert property (@(posedge clk) disable iff (!rst_n)
        fin_mode_reg |-> (state_reg != ST_IDLE && state_reg != ST_RESP))
        else $error("final-code mode leaked out of processing");
    a_resp_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RESP) |=> (state_reg == ST_IDLE))
        else $error("result load did not return to idle");

endmodule

### hw/rtl/lzwd_dp.sv
// Datapath of the LZW decoder: bit packer, dictionary, reversal stack, result register.
module lzwd_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [7:0]                      in_data,
    input  logic [1:0]                      in_kind,
    input  logic                            in_last,
    input  logic                            cfg_we,
    input  logic [lzwd_pkg::LIMIT_W-1:0]    cfg_wdata,
    input  lzwd_pkg::cmd_t                  cmd,
    output lzwd_pkg::status_t               sts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [23:0]                     out_data,
    output logic                            out_user
);
    import lzwd_pkg::*;

    logic [7:0]        prefix_dummy;
    logic [CODE_W-1:0] prefix_mem [0:DICT_SIZE-1];
    logic [7:0]        suffix_mem [0:DICT_SIZE-1];
    logic [7:0]        stack_mem  [0:STACK_SIZE-1];

    logic [1:0]         kind_reg;
    logic [7:0]         data_reg;
    logic               last_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [IDX_W-1:0]   depth_reg;
    logic [IDX_W-1:0]   base_reg;
    logic [IDX_W-1:0]   nfc_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [CODE_W-1:0]  prev_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [HELD_W-1:0]  held_reg;
    logic [LIMIT_W-1:0] emitted_reg;
    logic               first_reg;
    logic               done_reg;
    logic               ended_reg;
    logic [CODE_W-1:0]  code_reg;
    logic               first_mode_reg;
    logic               kw_reg;
    logic [CODE_W-1:0]  walk_code_reg;
    logic [IDX_W-1:0]   walk_n_reg;
    logic [7:0]         lit_reg;
    logic [CODE_W-1:0]  pre_rd_reg;
    logic [7:0]         suf_rd_reg;
    logic [7:0]         stack_rd_reg;
    logic [7:0]         pop_byte_reg;
    logic               pop_valid_reg;
    logic               rej_reg;
    logic               out_valid_reg;
    logic [23:0]        out_data_reg;
    logic               out_user_reg;

    logic [ACC_W-1:0]   new_acc;
    logic [HELD_W-1:0]  new_held;
    logic [CODE_W-1:0]  code_mask;
    logic [CODE_W-1:0]  push_code;
    logic [CODE_W-1:0]  fin_code;
    logic [LIMIT_W-1:0] room;
    logic [IDX_W-1:0]   take;
    logic [LIMIT_W-1:0] emitted_sum;
    logic [IDX_W-1:0]   nfc_inc;
    logic [IDX_W-1:0]   width_span;
    logic               dict_add;
    logic               stack_we;
    logic [IDX_W-1:0]   stack_waddr;
    logic [7:0]         stack_wdata;
    logic [IDX_W-1:0]   pop_addr;

    assign prefix_dummy = 8'd0;
    assign new_acc   = acc_reg | (ACC_W'(data_reg) << held_reg);
    assign new_held  = held_reg + HELD_W'(8);
    assign code_mask = CODE_W'((IDX_W'(1) << width_reg) - IDX_W'(1));
    assign push_code = new_acc[CODE_W-1:0] & code_mask;
    assign fin_code  = acc_reg[CODE_W-1:0] & code_mask;

    // emit: keep the first bytes of the string up to the limit
    assign room        = (emitted_reg < limit_reg) ? (limit_reg - emitted_reg) : '0;
    assign take        = (LIMIT_W'(walk_n_reg) < room) ? walk_n_reg : room[IDX_W-1:0];
    assign emitted_sum = emitted_reg + LIMIT_W'(take);
    assign nfc_inc     = nfc_reg + IDX_W'(1);
    assign width_span  = IDX_W'(1) << width_reg;
    assign dict_add    = !first_mode_reg && (nfc_reg < IDX_W'(DICT_SIZE));
    assign pop_addr    = base_reg + depth_reg - IDX_W'(1);

    always_comb
    begin
        stack_we    = 1'b0;
        stack_waddr = walk_n_reg;
        stack_wdata = suf_rd_reg;
        unique case (cmd.op)
            OP_CLASS:
            begin
                stack_we    = !(code_reg == END_CODE || code_reg == CLEAR_CODE) && first_reg;
                stack_waddr = '0;
                stack_wdata = code_reg[7:0];
            end
            OP_WALK_DAT: stack_we = 1'b1;
            OP_WALK_END:
            begin
                stack_we    = 1'b1;
                stack_wdata = walk_code_reg[7:0];
            end
            OP_EMIT:
            begin
                stack_we    = !first_mode_reg && kw_reg;
                stack_waddr = '0;
                stack_wdata = lit_reg;
            end
            default: stack_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        if (cmd.op == OP_POP_RD)
            stack_rd_reg <= stack_mem[pop_addr];
        if (cmd.op == OP_EMIT && dict_add)
        begin
            prefix_mem[nfc_reg[CODE_W-1:0]] <= prev_reg;
            suffix_mem[nfc_reg[CODE_W-1:0]] <= lit_reg;
        end
        if (cmd.op == OP_WALK_RD)
        begin
            pre_rd_reg <= prefix_mem[walk_code_reg];
            suf_rd_reg <= suffix_mem[walk_code_reg];
        end
    end

    // item latch and scratch registers without reset
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ACCEPT)
        begin
            kind_reg <= in_kind;
            data_reg <= in_data | prefix_dummy;
            last_reg <= in_last;
        end
        if (cmd.op == OP_PUSH)
            code_reg <= push_code;
        if (cmd.op == OP_FIN)
            code_reg <= fin_code;
        if (cmd.op == OP_CLASS)
        begin
            first_mode_reg <= first_reg;
            kw_reg         <= !(IDX_W'(code_reg) < nfc_reg);
            walk_code_reg  <= (IDX_W'(code_reg) < nfc_reg) ? code_reg : prev_reg;
            walk_n_reg     <= first_reg ? IDX_W'(1)
                            : ((IDX_W'(code_reg) < nfc_reg) ? '0 : IDX_W'(1));
        end
        if (cmd.op == OP_WALK_DAT)
        begin
            walk_n_reg    <= walk_n_reg + IDX_W'(1);
            walk_code_reg <= pre_rd_reg;
        end
        if (cmd.op == OP_WALK_END)
        begin
            walk_n_reg <= walk_n_reg + IDX_W'(1);
            lit_reg    <= walk_code_reg[7:0];
        end
        if (cmd.op == OP_POP_DAT)
            pop_byte_reg <= stack_rd_reg;
        if (cmd.op == OP_RESP)
        begin
            out_data_reg <= {1'b0, rej_reg, done_reg, depth_reg,
                             pop_valid_reg ? pop_byte_reg : 8'd0};
            out_user_reg <= pop_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            depth_reg     <= '0;
            base_reg      <= '0;
            nfc_reg       <= IDX_W'(FIRST_FREE);
            width_reg     <= START_WIDTH;
            prev_reg      <= '0;
            acc_reg       <= '0;
            held_reg      <= '0;
            emitted_reg   <= '0;
            first_reg     <= 1'b1;
            done_reg      <= 1'b0;
            ended_reg     <= 1'b0;
            pop_valid_reg <= 1'b0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (out_valid_reg && out_ready && cmd.op != OP_RESP)
                out_valid_reg <= 1'b0;
            unique case (cmd.op)
                OP_ACCEPT:
                begin
                    pop_valid_reg <= 1'b0;
                    rej_reg       <= 1'b0;
                end
                OP_PUSH:
                begin
                    if (depth_reg != '0 || done_reg)
                        rej_reg <= 1'b1;
                    else if (new_held >= HELD_W'(width_reg))
                    begin
                        acc_reg  <= new_acc >> width_reg;
                        held_reg <= new_held - HELD_W'(width_reg);
                    end
                    else
                    begin
                        acc_reg  <= new_acc;
                        held_reg <= new_held;
                    end
                end
                OP_CLASS:
                begin
                    priority if (code_reg == END_CODE)
                        done_reg <= 1'b1;
                    else if (code_reg == CLEAR_CODE)
                    begin
                        nfc_reg   <= IDX_W'(FIRST_FREE);
                        width_reg <= START_WIDTH;
                        first_reg <= 1'b1;
                    end
                    else if (first_reg)
                    begin
                        prev_reg  <= code_reg;
                        first_reg <= 1'b0;
                    end
                end
                OP_EMIT:
                begin
                    if (dict_add)
                    begin
                        nfc_reg <= nfc_inc;
                        if (nfc_inc >= width_span && width_reg < TOP_WIDTH)
                            width_reg <= width_reg + WIDTH_W'(1);
                    end
                    if (!first_mode_reg)
                        prev_reg <= code_reg;
                    depth_reg   <= take;
                    base_reg    <= walk_n_reg - take;
                    emitted_reg <= emitted_sum;
                    if (emitted_sum >= limit_reg)
                        done_reg <= 1'b1;
                end
                OP_LAST:
                    if (last_reg && depth_reg != '0)
                        ended_reg <= 1'b1;
                OP_FIN:
                begin
                    ended_reg <= 1'b0;
                    if (!done_reg && held_reg != '0)
                    begin
                        acc_reg  <= '0;
                        held_reg <= '0;
                    end
                end
                OP_SETDONE: done_reg <= 1'b1;
                OP_POP_RD:  depth_reg <= depth_reg - IDX_W'(1);
                OP_POP_DAT: pop_valid_reg <= 1'b1;
                OP_BEGIN:
                begin
                    depth_reg   <= '0;
                    nfc_reg     <= IDX_W'(FIRST_FREE);
                    width_reg   <= START_WIDTH;
                    prev_reg    <= '0;
                    acc_reg     <= '0;
                    held_reg    <= '0;
                    emitted_reg <= '0;
                    first_reg   <= 1'b1;
                    done_reg    <= 1'b0;
                    ended_reg   <= 1'b0;
                end
                OP_RESP:    out_valid_reg <= 1'b1;
                default:    ;
            endcase
        end
    end

    assign sts.kind       = kind_reg;
    assign sts.push_rej   = (depth_reg != '0) || done_reg;
    assign sts.code_ready = new_held >= HELD_W'(width_reg);
    assign sts.is_end     = code_reg == END_CODE;
    assign sts.is_clear   = code_reg == CLEAR_CODE;
    assign sts.is_first   = first_reg;
    assign sts.walk_go    = (walk_code_reg >= FIRST_FREE) && (walk_n_reg < IDX_W'(DICT_SIZE));
    assign sts.last       = last_reg;
    assign sts.depth_zero = depth_reg == '0;
    assign sts.in_ended   = ended_reg;
    assign sts.fin_go     = !done_reg && (held_reg != '0);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= IDX_W'(STACK_SIZE))
        else $error("stack depth beyond stack size");
    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg >= START_WIDTH) && (width_reg <= TOP_WIDTH))
        else $error("code width out of range");
    a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nfc_reg >= IDX_W'(FIRST_FREE)) && (nfc_reg <= IDX_W'(DICT_SIZE)))
        else $error("next free code out of range");
    a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |=> (emitted_reg <= limit_reg || $past(emitted_reg) > limit_reg))
        else $error("emitted count passed the limit");

endmodule

### hw/rtl/lzw_variable_width_decoder_core.sv
// Top level of the LZW variable-width decoder: controller plus datapath.
// From accept to result: a pull pops one byte unless nothing is pending; a push without a
// full code only packs its byte; a push that completes a code also walks its chain, with
// one dictionary read and one stack write per step, and a final padded code likewise.
// Throughput: one transaction in flight; the next is taken the cycle after the result loads.
// Reset: rst_n clears control state asynchronously, the limit returns to 2^24; tables are kept.
module lzw_variable_width_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: output byte limit
    input  logic        cfg_we,
    input  logic [24:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic        s_tlast,   // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [20:8] pending_count, [21] done_res,
                                   // [22] rejected, [23] zero
    output logic        m_tuser    // byte_valid
);
    import lzwd_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // sequence each transaction through the datapath
    lzwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold the stream state, dictionary and reversal stack
    lzwd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .in_kind   (s_tuser),
        .in_last   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

### tb/tb_lzw_variable_width_decoder_core.sv
// Self-checking testbench for the LZW variable-width decoder core.
`timescale 1ns / 100ps

module tb_lzw_variable_width_decoder_core;
    import lzwd_pkg::*;

    // Spare kind that the block must ignore apart from reporting its status.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic [12:0] pending;
        logic        done;
        logic        rejected;
    } decode_result_t;

    // Bit-exact decoder model plus the queue of results it has predicted.
    class lzw_decode_scoreboard;
        logic [CODE_W-1:0]  prefix_mem [DICT_SIZE];
        logic [7:0]         suffix_mem [DICT_SIZE];
        logic [7:0]         lifo [STACK_SIZE];
        int unsigned        limit;
        int unsigned        depth;
        int unsigned        free_code;
        int unsigned        width;
        int unsigned        prev_code;
        int unsigned        acc;
        int unsigned        held;
        int unsigned        emitted;
        bit                 first_pending;
        bit                 done;
        bit                 input_ended;
        decode_result_t     pending_results [$];
        int                 mismatches;
        int                 checked;

        function void restart();
            depth = 0;
            free_code = FIRST_FREE;
            width = START_WIDTH;
            prev_code = 0;
            acc = 0;
            held = 0;
            emitted = 0;
            first_pending = 1;
            done = 0;
            input_ended = 0;
        endfunction

        function new();
            limit = LIMIT_RESET;
            mismatches = 0;
            checked = 0;
            restart();
        endfunction

        // Expand a chain onto the stack from index start; return the new depth.
        function int unsigned expand(int unsigned code, int unsigned start);
            int unsigned n;
            n = start;
            while (code >= FIRST_FREE && code < DICT_SIZE && n < DICT_SIZE)
            begin
                lifo[n] = suffix_mem[code];
                code = prefix_mem[code];
                n++;
            end
            lifo[n] = code[7:0];
            return n + 1;
        endfunction

        // Keep only the first bytes of the string that fit under the limit.
        function void deliver(int unsigned n);
            int unsigned room;
            int unsigned k;
            room = (emitted < limit) ? limit - emitted : 0;
            k = (n < room) ? n : room;
            if (k < n)
                for (int i = 0; i < k; i++)
                    lifo[i] = lifo[i + n - k];
            depth = k;
            emitted += k;
            if (emitted >= limit)
                done = 1;
        endfunction

        function void decode_code(int unsigned c);
            int unsigned n;
            if (c == END_CODE)
            begin
                done = 1;
                return;
            end
            if (c == CLEAR_CODE)
            begin
                free_code = FIRST_FREE;
                width = START_WIDTH;
                first_pending = 1;
                return;
            end
            if (first_pending)
            begin
                lifo[0] = c[7:0];
                prev_code = c;
                first_pending = 0;
                deliver(1);
                return;
            end
            if (c < free_code)
                n = expand(c, 0);
            else
            begin
                // string repeats its own first byte
                n = expand(prev_code, 1);
                lifo[0] = lifo[n - 1];
            end
            if (free_code < DICT_SIZE)
            begin
                prefix_mem[free_code] = prev_code[CODE_W-1:0];
                suffix_mem[free_code] = lifo[n - 1];
                free_code++;
                if (free_code >= (1 << width) && width < MAX_CODE_BITS)
                    width++;
            end
            prev_code = c;
            deliver(n);
        endfunction

        function void flush_input();
            int unsigned c;
            input_ended = 0;
            if (!done && held > 0)
            begin
                c = acc & ((1 << width) - 1);
                acc = 0;
                held = 0;
                decode_code(c);
            end
            done = 1;
        endfunction

        // Apply one accepted input transaction and queue the result it causes.
        function void note_input(logic [1:0] kind, logic [7:0] data, logic last);
            decode_result_t r;
            int unsigned c;
            r.byte_valid = 0;
            r.out_byte = 0;
            r.rejected = 0;
            if (kind == KIND_PUSH)
            begin
                if (depth > 0 || done)
                    r.rejected = 1;
                else
                begin
                    acc |= int'(data) << held;
                    held += 8;
                    if (held >= width)
                    begin
                        c = acc & ((1 << width) - 1);
                        acc >>= width;
                        held -= width;
                        decode_code(c);
                    end
                    if (last)
                    begin
                        if (depth == 0)
                            flush_input();
                        else
                            input_ended = 1;
                    end
                end
            end
            else if (kind == KIND_PULL)
            begin
                if (depth > 0)
                begin
                    depth--;
                    r.out_byte = lifo[depth];
                    r.byte_valid = 1;
                    if (depth == 0 && input_ended)
                        flush_input();
                end
            end
            else if (kind == KIND_BEGIN)
                restart();
            r.pending = depth[12:0];
            r.done = done;
            pending_results.push_back(r);
        endfunction

        // Compare one output transaction with the oldest prediction.
        function void check_result(logic valid, logic [23:0] d);
            decode_result_t e;
            checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result tuser=%0b tdata=%h", valid, d);
                return;
            end
            e = pending_results.pop_front();
            if (valid !== e.byte_valid || d[7:0] !== e.out_byte || d[20:8] !== e.pending
                || d[21] !== e.done || d[22] !== e.rejected || d[23] !== 1'b0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result %0d expected v=%0b b=%h p=%0d d=%0b r=%0b",
                             checked, e.byte_valid, e.out_byte, e.pending, e.done,
                             e.rejected);
                    $display("       actual v=%0b b=%h p=%0d d=%0b r=%0b",
                             valid, d[7:0], d[20:8], d[21], d[22]);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [24:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    lzw_decode_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int items_sent;
    int streams_run;

    // Encoder shadow of the decoder's code width bookkeeping.
    int unsigned    enc_next;
    int unsigned    enc_width;
    bit             enc_first;
    longint unsigned enc_bits;
    int             enc_nbits;
    int unsigned    stream_codes [$];
    logic [7:0]     stream_bytes [$];

    lzw_variable_width_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Check every output transaction, then roll the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Drive one input transaction and hold it until the block takes it.
    task automatic send(logic [1:0] kind, logic [7:0] data, logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(kind, data, last);
        items_sent++;
    endtask

    // Drain all expected results, then let the block settle before a write.
    task automatic wait_idle();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (sb.pending_results.size() > 0 && guard < 400000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
    endtask

    task automatic write_limit(int unsigned value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[24:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.limit = value;
    endtask

    // Pack one code LSB first at the width the decoder will read it with.
    function automatic void pack_code(int unsigned c);
        stream_codes.push_back(c);
        enc_bits |= longint'(c) << enc_nbits;
        enc_nbits += enc_width;
        while (enc_nbits >= 8)
        begin
            stream_bytes.push_back(enc_bits[7:0]);
            enc_bits >>= 8;
            enc_nbits -= 8;
        end
        if (c == CLEAR_CODE)
        begin
            enc_next = FIRST_FREE;
            enc_width = START_WIDTH;
            enc_first = 1;
        end
        else if (c != END_CODE)
        begin
            if (enc_first)
                enc_first = 0;
            else if (enc_next < DICT_SIZE)
            begin
                enc_next++;
                if (enc_next >= (1 << enc_width) && enc_width < MAX_CODE_BITS)
                    enc_width++;
            end
        end
    endfunction

    function automatic void encode_start();
        enc_next = FIRST_FREE;
        enc_width = START_WIDTH;
        enc_first = 1;
        enc_bits = 0;
        enc_nbits = 0;
        stream_codes.delete();
        stream_bytes.delete();
    endfunction

    function automatic void encode_finish();
        if (enc_nbits > 0)
            stream_bytes.push_back(enc_bits[7:0]);
        enc_nbits = 0;
    endfunction

    // Build a random well-formed code stream. A code whose string would later
    // be chained through an entry never written is followed by an end code.
    function automatic void build_stream(int ncodes, bit literals_only);
        int unsigned c;
        int r;
        bit hazard;
        bit ended;
        encode_start();
        hazard = 0;
        ended = 0;
        for (int i = 0; i < ncodes && !ended; i++)
        begin
            r = $urandom_range(99);
            if (hazard)
                c = END_CODE;
            else if (literals_only)
                c = $urandom_range(255);
            else if (enc_first)
            begin
                if (r < 5)
                    c = CLEAR_CODE;
                else if (r < 9)
                begin
                    c = $urandom_range(DICT_SIZE - 1, FIRST_FREE);
                    hazard = 1;
                end
                else
                    c = $urandom_range(255);
            end
            else if (r < 55)
                c = $urandom_range(255);
            else if (r < 80 && enc_next > FIRST_FREE)
                c = $urandom_range(enc_next - 1, FIRST_FREE);
            else if (r < 90 && enc_next < DICT_SIZE)
                c = enc_next;
            else if (r < 93)
                c = CLEAR_CODE;
            else if (r < 95 && enc_next < DICT_SIZE - 1)
            begin
                c = $urandom_range(DICT_SIZE - 1, enc_next + 1);
                hazard = 1;
            end
            else
                c = $urandom_range(255);
            ended = (c == END_CODE);
            pack_code(c);
        end
        if (!ended && (hazard || $urandom_range(99) < 40))
            pack_code(END_CODE);
        encode_finish();
    endfunction

    // Feed the prepared bytes as one stream, pulling whenever bytes are pending.
    task automatic run_stream(bit allow_noise);
        int last_idx;
        int idx;
        int r;
        send(KIND_BEGIN, 8'($urandom), 1'($urandom));
        streams_run++;
        last_idx = stream_bytes.size() - 1;
        if (allow_noise && $urandom_range(99) < 8)
            last_idx = $urandom_range(last_idx);
        idx = 0;
        while (idx <= last_idx && !sb.done)
        begin
            r = $urandom_range(99);
            if (sb.depth > 0)
            begin
                if (allow_noise && r < 4)
                    send(KIND_PUSH, 8'($urandom), 1'($urandom));
                else if (allow_noise && r < 6)
                    send(KIND_SPARE, 8'($urandom), 1'($urandom));
                else if (allow_noise && r < 7)
                begin
                    // abandon the stream with bytes still pending
                    send(KIND_BEGIN, 8'($urandom), 1'($urandom));
                    return;
                end
                else
                    send(KIND_PULL, 8'($urandom), 1'($urandom));
            end
            else
            begin
                send(KIND_PUSH, stream_bytes[idx], idx == last_idx);
                idx++;
            end
        end
        while (sb.depth > 0)
            send(KIND_PULL, 8'($urandom), 1'($urandom));
        if (allow_noise && $urandom_range(99) < 25)
            send(KIND_PUSH, 8'($urandom), 1'($urandom));
        if (allow_noise && $urandom_range(99) < 25)
            send(KIND_PULL, 8'($urandom), 1'($urandom));
    endtask

    task automatic directed_stream(int unsigned a, int unsigned b, int unsigned c,
                                   int unsigned d, int unsigned e, int unsigned f);
        encode_start();
        pack_code(a);
        pack_code(b);
        pack_code(c);
        pack_code(d);
        pack_code(e);
        pack_code(f);
        encode_finish();
        run_stream(0);
    endtask

    initial
    begin
        int target;
        int guard;
        sb = new();
        send_idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        streams_run = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_PULL;
        s_tlast = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: clear as first code, literals, chained code, repeated-string
        // code, end code; then empty pull, spare kind, push after done.
        directed_stream(CLEAR_CODE, 8'h41, 8'h42, 258, 260, END_CODE);
        directed_stream(8'hFF, 8'h00, 258, 8'hFF, 259, END_CODE);
        send(KIND_PULL, 8'h00, 1'b0);
        send(KIND_SPARE, 8'hA5, 1'b1);
        send(KIND_PUSH, 8'hFF, 1'b1);
        // high first code emits only its low byte
        directed_stream(CLEAR_CODE, CLEAR_CODE, 300, END_CODE, 8'h11, 8'h22);

        // Long literal stream: walk the width from 9 to 10.
        write_limit(25'd16777216);
        build_stream(280, 1);
        run_stream(0);
        // a few random codes over the tables left behind
        build_stream(12, 0);
        run_stream(1);

        // Random phases with different idling and limits.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            case (phase)
                0: write_limit(25'd1);
                1: write_limit($urandom_range(200, 5));
                2: write_limit(25'd16777216);
                default: write_limit($urandom_range(60, 2));
            endcase
            target = items_sent + 35;
            while (items_sent < target)
            begin
                build_stream($urandom_range(16, 4), 0);
                run_stream(1);
            end
        end

        s_tvalid <= 1'b0;
        guard = 0;
        while (sb.pending_results.size() > 0 && guard < 400000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
        if (sb.pending_results.size() > 0)
        begin
            sb.mismatches += sb.pending_results.size();
            $display("ERROR: %0d expected results never arrived", sb.pending_results.size());
        end

        $display("Covered %0d input transactions over %0d streams, %0d results checked.",
                 items_sent, streams_run, sb.checked);
        $display("Limits 1, small, 2^24; code widths 9 and 10; four idle mixes.");
        if (sb.mismatches == 0)
            $display("lzw_variable_width_decoder_core test passed");
        else
            $display("lzw_variable_width_decoder_core test failed");
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #40ms;
        $display("lzw_variable_width_decoder_core test failed");
        $finish;
    end

endmodule
